// File: sv/triangle_face_normal_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle face normal block.
// Every use sits inside a module that has clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// cons must hold in the same cycle as ante
`define TFN_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define TFN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, constants and types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned LANES           = 3;

  // normalized cross product component, leading one of the largest at bit 30
  localparam int unsigned MANT_W = 31;
  localparam int unsigned SQR_W  = 2 * MANT_W;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned ROOT_W = 32;

  // quotient q = ((m << FRAC_W) + len) / (2 * len), rounds half away from zero
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned QUOT_W = 15;
  localparam int unsigned NUM_W  = MANT_W + FRAC_W + 1;
  localparam int unsigned DEN_W  = ROOT_W + 1;
  localparam int unsigned OUT_W  = 16;

  localparam int unsigned        UNIT_SHIFT = 14;
  localparam logic [QUOT_W-1:0] UNIT_Q     = QUOT_W'(1) << UNIT_SHIFT;

  typedef struct packed {
    logic             degen;
    logic [LANES-1:0] neg;
  } tfn_flags_t;

  typedef struct packed {
    tfn_flags_t                   flags;
    logic [LANES-1:0][MANT_W-1:0] mant;
  } tfn_vec_t;

endpackage

`default_nettype wire

// File: sv/tfn_if.sv
// ----------------------------------------------------------------------------
// tfn_if
// Request channels of the face normal block: triangle in, unit normal out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_tri_if #(
  parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface tfn_norm_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfn_pkg::OUT_W-1:0] normal_x;
  logic signed [tfn_pkg::OUT_W-1:0] normal_y;
  logic signed [tfn_pkg::OUT_W-1:0] normal_z;
  logic                                degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal normalize((c - a) x (b - a)) of one triangle, Q2.14 in,
// Q1.14 out; a zero cross product gives a zero vector and the degenerate flag.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  tri_i    in   a_x a_y a_z b_x b_y b_z c_x c_y c_z (COORD_WIDTH, signed)
//  norm_o   out  normal_x normal_y normal_z (16, signed), degenerate
//
//  One request per cycle while norm_o is not stalled; the depth is set by
//  the front stages, the 32 root-bit stages of the square root
//  and the 15 quotient-bit stages of the divider.
//  Reset clears the valid bits of every stage; payload registers hold.
//  Each stage loads when empty or when its content moves on, so a stalled
//  result holds in the output register while earlier stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_face_normal_macros.svh"

module triangle_face_normal #(
  parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfn_tri_if.sink    tri_i,
  tfn_norm_if.source norm_o
);

  localparam int unsigned EdgeW   = COORD_WIDTH + 1;
  localparam int unsigned ProdW   = 2 * EdgeW;
  localparam int unsigned NormW   =
    1 << $clog2(ProdW > tfn_pkg::MANT_W ? ProdW : tfn_pkg::MANT_W);
  localparam int unsigned NormSt  = $clog2(NormW);
  localparam int unsigned NormBase = 4;
  localparam int unsigned SqSt    = NormBase + NormSt;
  localparam int unsigned SumSt   = SqSt + 1;
  localparam int unsigned FrontSt = SumSt + 1;
  localparam int unsigned Lanes   = tfn_pkg::LANES;

  // --------------------------------------------------------------------------
  // Front pipeline control
  // --------------------------------------------------------------------------
  logic [FrontSt-1:0] fv_q;
  logic [FrontSt-1:0] fv_in;
  logic [FrontSt-1:0] fld;
  logic               sq_ready;

  assign fv_in = {fv_q[FrontSt-2:0], tri_i.valid};

  for (genvar k = 0; k < FrontSt; k++) begin : g_ld
    if (k == FrontSt - 1) begin : g_last
      assign fld[k] = !fv_q[k] || sq_ready;
    end else begin : g_mid
      assign fld[k] = !fv_q[k] || fld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      for (int k = 0; k < FrontSt; k++) begin
        if (fld[k]) begin
          fv_q[k] <= fv_in[k];
        end
      end
    end
  end

  assign tri_i.ready = fld[0];

  // --------------------------------------------------------------------------
  // Edges e1 = c - a, e2 = b - a
  // --------------------------------------------------------------------------
  logic signed [EdgeW-1:0] a_s  [Lanes];
  logic signed [EdgeW-1:0] b_s  [Lanes];
  logic signed [EdgeW-1:0] c_s  [Lanes];
  logic signed [EdgeW-1:0] e1_q [Lanes];
  logic signed [EdgeW-1:0] e2_q [Lanes];

  assign a_s[0] = {tri_i.a_x[COORD_WIDTH-1], tri_i.a_x};
  assign a_s[1] = {tri_i.a_y[COORD_WIDTH-1], tri_i.a_y};
  assign a_s[2] = {tri_i.a_z[COORD_WIDTH-1], tri_i.a_z};
  assign b_s[0] = {tri_i.b_x[COORD_WIDTH-1], tri_i.b_x};
  assign b_s[1] = {tri_i.b_y[COORD_WIDTH-1], tri_i.b_y};
  assign b_s[2] = {tri_i.b_z[COORD_WIDTH-1], tri_i.b_z};
  assign c_s[0] = {tri_i.c_x[COORD_WIDTH-1], tri_i.c_x};
  assign c_s[1] = {tri_i.c_y[COORD_WIDTH-1], tri_i.c_y};
  assign c_s[2] = {tri_i.c_z[COORD_WIDTH-1], tri_i.c_z};

  always_ff @(posedge clk_i) begin
    if (fld[0]) begin
      for (int i = 0; i < Lanes; i++) begin
        e1_q[i] <= c_s[i] - a_s[i];
        e2_q[i] <= b_s[i] - a_s[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cross product: six products, then differences, then magnitudes
  // --------------------------------------------------------------------------
  logic signed [ProdW-1:0] p_q   [2*Lanes];
  logic signed [ProdW-1:0] n_q   [Lanes];
  logic        [ProdW-1:0] mag_q [Lanes];
  logic        [Lanes-1:0] neg_q;

  always_ff @(posedge clk_i) begin
    if (fld[1]) begin
      p_q[0] <= ProdW'(e1_q[1]) * ProdW'(e2_q[2]);
      p_q[1] <= ProdW'(e1_q[2]) * ProdW'(e2_q[1]);
      p_q[2] <= ProdW'(e1_q[2]) * ProdW'(e2_q[0]);
      p_q[3] <= ProdW'(e1_q[0]) * ProdW'(e2_q[2]);
      p_q[4] <= ProdW'(e1_q[0]) * ProdW'(e2_q[1]);
      p_q[5] <= ProdW'(e1_q[1]) * ProdW'(e2_q[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld[2]) begin
      for (int i = 0; i < Lanes; i++) begin
        n_q[i] <= p_q[2*i] - p_q[2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld[3]) begin
      for (int i = 0; i < Lanes; i++) begin
        mag_q[i] <= n_q[i][ProdW-1] ? $unsigned(-n_q[i]) : $unsigned(n_q[i]);
        neg_q[i] <= n_q[i][ProdW-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normalize: shift all three left together until the leading one of the
  // largest reaches the top, halving the step at each stage
  // --------------------------------------------------------------------------
  logic [Lanes-1:0][NormW-1:0] nv_q   [NormSt];
  logic [Lanes-1:0]            nneg_q [NormSt];

  for (genvar k = 0; k < NormSt; k++) begin : g_norm
    localparam int unsigned Sh = 2 ** (NormSt - 1 - k);

    logic [Lanes-1:0][NormW-1:0] src;
    logic [Lanes-1:0]            src_neg;
    logic                        hi_zero;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < Lanes; i++) begin
          src[i] = NormW'(mag_q[i]);
        end
      end
      assign src_neg = neg_q;
    end else begin : g_next
      assign src     = nv_q[k-1];
      assign src_neg = nneg_q[k-1];
    end

    assign hi_zero = ~|(src[0][NormW-1 -: Sh] | src[1][NormW-1 -: Sh] |
                        src[2][NormW-1 -: Sh]);

    always_ff @(posedge clk_i) begin
      if (fld[NormBase + k]) begin
        for (int i = 0; i < Lanes; i++) begin
          nv_q[k][i] <= hi_zero ? (src[i] << Sh) : src[i];
        end
        nneg_q[k] <= src_neg;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Squares and their sum
  // --------------------------------------------------------------------------
  logic [Lanes-1:0][tfn_pkg::MANT_W-1:0] mant_s;
  logic [tfn_pkg::SQR_W-1:0]             sqr_q [Lanes];
  tfn_pkg::tfn_vec_t                     vec_sq_q;
  tfn_pkg::tfn_vec_t                     vec_sum_q;
  logic [tfn_pkg::SUM_W-1:0]             sum_q;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mant_s[i] = nv_q[NormSt-1][i][NormW-1 -: tfn_pkg::MANT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld[SqSt]) begin
      // all zero after full normalization means a zero cross product
      vec_sq_q.flags.degen <= ~(mant_s[0][tfn_pkg::MANT_W-1] |
                                mant_s[1][tfn_pkg::MANT_W-1] |
                                mant_s[2][tfn_pkg::MANT_W-1]);
      vec_sq_q.flags.neg   <= nneg_q[NormSt-1];
      vec_sq_q.mant        <= mant_s;
      for (int i = 0; i < Lanes; i++) begin
        sqr_q[i] <= tfn_pkg::SQR_W'(mant_s[i]) * tfn_pkg::SQR_W'(mant_s[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld[SumSt]) begin
      sum_q     <= tfn_pkg::SUM_W'(sqr_q[0]) + tfn_pkg::SUM_W'(sqr_q[1])
                   + tfn_pkg::SUM_W'(sqr_q[2]);
      vec_sum_q <= vec_sq_q;
    end
  end

  // --------------------------------------------------------------------------
  // Length and division
  // --------------------------------------------------------------------------
  logic                                           rt_valid;
  logic                                           rt_ready;
  logic [tfn_pkg::ROOT_W-1:0]                     rt_root;
  tfn_pkg::tfn_vec_t                              rt_vec;
  logic                                           dv_valid;
  logic [Lanes-1:0][tfn_pkg::QUOT_W-1:0]          dv_quot;
  tfn_pkg::tfn_flags_t                            dv_flags;
  logic                                           out_ld;

  tfn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q[FrontSt-1]),
    .ready_o (sq_ready),
    .sum_i   (sum_q),
    .vec_i   (vec_sum_q),
    .valid_o (rt_valid),
    .ready_i (rt_ready),
    .root_o  (rt_root),
    .vec_o   (rt_vec)
  );

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .ready_o (rt_ready),
    .root_i  (rt_root),
    .vec_i   (rt_vec),
    .valid_o (dv_valid),
    .ready_i (out_ld),
    .quot_o  (dv_quot),
    .flags_o (dv_flags)
  );

  // --------------------------------------------------------------------------
  // Output register: apply sign, force zero on a degenerate triangle
  // --------------------------------------------------------------------------
  logic                                 out_v_q;
  logic [Lanes-1:0][tfn_pkg::OUT_W-1:0] nrm_q;
  logic                                 deg_q;

  assign out_ld = !out_v_q || norm_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      for (int i = 0; i < Lanes; i++) begin
        if (dv_flags.degen) begin
          nrm_q[i] <= '0;
        end else if (dv_flags.neg[i]) begin
          nrm_q[i] <= ~tfn_pkg::OUT_W'(dv_quot[i]) + tfn_pkg::OUT_W'(1);
        end else begin
          nrm_q[i] <= tfn_pkg::OUT_W'(dv_quot[i]);
        end
      end
      deg_q <= dv_flags.degen;
    end
  end

  assign norm_o.valid      = out_v_q;
  assign norm_o.normal_x   = nrm_q[0];
  assign norm_o.normal_y   = nrm_q[1];
  assign norm_o.normal_z   = nrm_q[2];
  assign norm_o.degenerate = deg_q;

  // an empty output register lets requests flow in
  `TFN_ASSERT_IMPL(a_ready_when_out_empty, !norm_o.valid, tri_i.ready,
                   "input stalled with empty output")
  // an accepted request lands in the first stage
  `TFN_ASSERT_NEXT(a_accept_lands, tri_i.valid && tri_i.ready, fv_q[0],
                   "accepted request lost")
  // a proper triangle never yields a zero normal
  `TFN_ASSERT_IMPL(a_nondegen_nonzero, norm_o.valid && !norm_o.degenerate,
                   norm_o.normal_x != '0 || norm_o.normal_y != '0 ||
                   norm_o.normal_z != '0, "zero normal without degenerate flag")

endmodule

`default_nettype wire

// File: sv/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one root bit per stage, sideband carried.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_face_normal_macros.svh"

module tfn_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [tfn_pkg::SUM_W-1:0]    sum_i,
  input  tfn_pkg::tfn_vec_t            vec_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [tfn_pkg::ROOT_W-1:0]   root_o,
  output tfn_pkg::tfn_vec_t            vec_o
);

  localparam int unsigned Steps = tfn_pkg::ROOT_W;
  localparam int unsigned RemW  = tfn_pkg::SUM_W + 2;

  logic [Steps-1:0]                v_q;
  logic [Steps-1:0]                v_in;
  logic [Steps-1:0]                ld;
  logic [tfn_pkg::SUM_W-1:0]       rem_q  [Steps];
  logic [tfn_pkg::ROOT_W-1:0]      root_q [Steps];
  tfn_pkg::tfn_vec_t               vec_q  [Steps];

  assign v_in = {v_q[Steps-2:0], valid_i};

  // a stage loads when it is empty or its content moves on
  for (genvar k = 0; k < Steps; k++) begin : g_ld
    if (k == Steps - 1) begin : g_last
      assign ld[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Steps; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - j;

    logic [tfn_pkg::SUM_W-1:0]  rem_s;
    logic [tfn_pkg::ROOT_W-1:0] root_s;
    tfn_pkg::tfn_vec_t          vec_s;
    logic [RemW-1:0]            rem_w;
    logic [RemW-1:0]            trial;
    logic                       fits;

    if (j == 0) begin : g_first
      assign rem_s  = sum_i;
      assign root_s = '0;
      assign vec_s  = vec_i;
    end else begin : g_next
      assign rem_s  = rem_q[j-1];
      assign root_s = root_q[j-1];
      assign vec_s  = vec_q[j-1];
    end

    // (root + 2^Bit)^2 - root^2; root holds only bits above Bit
    assign trial = (RemW'(root_s) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign rem_w = RemW'(rem_s);
    assign fits  = rem_w >= trial;

    always_ff @(posedge clk_i) begin
      if (ld[j]) begin
        rem_q[j]  <= fits ? tfn_pkg::SUM_W'(rem_w - trial) : rem_s;
        root_q[j] <= fits ? (root_s | (tfn_pkg::ROOT_W'(1) << Bit)) : root_s;
        vec_q[j]  <= vec_s;
      end
    end
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign vec_o   = vec_q[Steps-1];

  // a nondegenerate vector has its largest component in [2^30, 2^31)
  `TFN_ASSERT_IMPL(a_root_in_range, valid_o && !vec_o.flags.degen,
                   root_o[Steps-1] || root_o[Steps-2], "square root below 2^30")

endmodule

`default_nettype wire

// File: sv/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage after a setup stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_face_normal_macros.svh"

module tfn_div (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [tfn_pkg::ROOT_W-1:0]                       root_i,
  input  tfn_pkg::tfn_vec_t                                vec_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [tfn_pkg::LANES-1:0][tfn_pkg::QUOT_W-1:0]   quot_o,
  output tfn_pkg::tfn_flags_t                              flags_o
);

  localparam int unsigned Stages = tfn_pkg::QUOT_W + 1;
  localparam int unsigned RemW   = tfn_pkg::NUM_W + 1;

  logic [Stages-1:0]                                     v_q;
  logic [Stages-1:0]                                     v_in;
  logic [Stages-1:0]                                     ld;
  logic [tfn_pkg::LANES-1:0][tfn_pkg::NUM_W-1:0]         rem_q [Stages];
  logic [tfn_pkg::LANES-1:0][tfn_pkg::QUOT_W-1:0]        q_q   [Stages];
  logic [tfn_pkg::DEN_W-1:0]                             den_q [Stages];
  tfn_pkg::tfn_flags_t                                   flg_q [Stages];

  assign v_in = {v_q[Stages-2:0], valid_i};

  for (genvar k = 0; k < Stages; k++) begin : g_ld
    if (k == Stages - 1) begin : g_last
      assign ld[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // setup: numerator (m << 15) + len, divisor 2 * len
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        rem_q[0][i] <= (tfn_pkg::NUM_W'(vec_i.mant[i]) << tfn_pkg::FRAC_W)
                       + tfn_pkg::NUM_W'(root_i);
      end
      q_q[0]   <= '0;
      den_q[0] <= {root_i, 1'b0};
      flg_q[0] <= vec_i.flags;
    end
  end

  for (genvar j = 1; j < Stages; j++) begin : g_step
    localparam int unsigned Bit = tfn_pkg::QUOT_W - j;

    logic [RemW-1:0]                                 trial;
    logic [tfn_pkg::LANES-1:0][tfn_pkg::NUM_W-1:0]   rem_d;
    logic [tfn_pkg::LANES-1:0][tfn_pkg::QUOT_W-1:0]  q_d;

    assign trial = RemW'(den_q[j-1]) << Bit;

    for (genvar i = 0; i < tfn_pkg::LANES; i++) begin : g_lane
      logic [RemW-1:0] rem_w;
      logic            fits;

      assign rem_w    = RemW'(rem_q[j-1][i]);
      assign fits     = rem_w >= trial;
      assign rem_d[i] = fits ? tfn_pkg::NUM_W'(rem_w - trial) : rem_q[j-1][i];
      assign q_d[i]   = fits ? (q_q[j-1][i] | (tfn_pkg::QUOT_W'(1) << Bit))
                             : q_q[j-1][i];
    end

    always_ff @(posedge clk_i) begin
      if (ld[j]) begin
        rem_q[j] <= rem_d;
        q_q[j]   <= q_d;
        den_q[j] <= den_q[j-1];
        flg_q[j] <= flg_q[j-1];
      end
    end
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[Stages-1];
  assign quot_o  = q_q[Stages-1];
  assign flags_o = flg_q[Stages-1];

  // no component of a unit vector exceeds one
  `TFN_ASSERT_IMPL(a_quot_le_unit, valid_o && !flags_o.degen,
                   quot_o[0] <= tfn_pkg::UNIT_Q && quot_o[1] <= tfn_pkg::UNIT_Q &&
                   quot_o[2] <= tfn_pkg::UNIT_Q, "normal component above one")

endmodule

`default_nettype wire
